>>> sv/wct_pkg.sv
package wct_pkg;

    // Table geometry.
    localparam int unsigned CAPACITY = 4096;
    localparam int unsigned IDX_W    = $clog2(CAPACITY);
    localparam logic [31:0] COOLDOWN_RESET = 32'd300;

    // Command codes of an input word.
    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    // One table entry as stored in memory.
    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [7:0]  owner;
        logic [31:0] frame;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    // One result word.
    typedef struct packed {
        logic        conflict;
        logic [7:0]  contender_id;
        logic [33:0] signature;
        logic        overflow;
    } result_t;

    // Memory access request from the controller.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    // Controller status toward the top level.
    typedef struct packed {
        logic idle;
        logic done;
    } ctrl_status_t;

    // Signature over the pair of ids, taken in sorted order, and the address.
    function automatic logic [33:0] pair_signature(
        input logic [7:0]  x,
        input logic [7:0]  y,
        input logic [31:0] a
    );
        logic [7:0] lo;
        logic [7:0] hi;
        lo = (x < y) ? x : y;
        hi = (x < y) ? y : x;
        return {26'd0, lo} ^ {25'd0, hi, 1'b0} ^ {a, 2'b00};
    endfunction

endpackage

>>> sv/write_conflict_tracker_unit.sv
// Write conflict tracker.
// Input channel (in_valid / in_stall) carries one word: cmd, address,
// writer_id and frame_number. Output channel (out_valid / out_stall) returns
// one result word per input word: conflict, contender_id, signature and
// overflow. The cfg channel (cfg_valid / cfg_ready) writes the cooldown
// register; write it only while the block is idle.
// One word is in work at a time. An observe sweeps the table memory, one
// entry per cycle over its single read port: a hit ends the sweep early,
// and a miss on a full table adds a prune sweep. A clear writes every
// entry once. Observes with writer_id 0 skip the table. After reset a
// clearing pass writes every entry, during which in_stall stays high;
// cooldown returns to 300.
// The result sits in an output register; a new input word is accepted while
// it waits. If the receiver stalls, the next result waits in the block and
// in_stall stays high until the output register frees up.
module write_conflict_tracker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [31:0] address,
    input  logic [7:0]  writer_id,
    input  logic [31:0] frame_number,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        conflict,
    output logic [7:0]  contender_id,
    output logic [33:0] signature,
    output logic        overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    wct_pkg::mem_req_t     mem_req;
    wct_pkg::entry_t       rdata;
    wct_pkg::result_t      res;
    wct_pkg::ctrl_status_t status;

    logic             item_take;
    logic             res_take;
    logic [31:0]      cooldown_reg;
    logic             out_valid_reg;
    wct_pkg::result_t out_reg;

    assign in_stall  = !status.idle;
    assign item_take = in_valid && status.idle;
    assign res_take  = status.done && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;

    wct_ram #(
        .WIDTH(wct_pkg::ENTRY_W),
        .DEPTH(wct_pkg::CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (mem_req.we),
        .waddr(mem_req.waddr),
        .wdata(mem_req.wdata),
        .re   (mem_req.re),
        .raddr(mem_req.raddr),
        .rdata(rdata)
    );

    wct_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_take   (item_take),
        .cmd         (cmd),
        .address     (address),
        .writer_id   (writer_id),
        .frame_number(frame_number),
        .cooldown    (cooldown_reg),
        .res_take    (res_take),
        .rdata       (rdata),
        .mem_req     (mem_req),
        .res         (res),
        .status      (status)
    );

    // Cooldown register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooldown_reg <= wct_pkg::COOLDOWN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cooldown_reg <= cfg_data;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign conflict     = out_reg.conflict;
    assign contender_id = out_reg.contender_id;
    assign signature    = out_reg.signature;
    assign overflow     = out_reg.overflow;

endmodule

>>> sv/wct_ram.sv
module wct_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/wct_ctrl.sv
module wct_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_take,
    input  logic                  cmd,
    input  logic [31:0]           address,
    input  logic [7:0]            writer_id,
    input  logic [31:0]           frame_number,
    input  logic [31:0]           cooldown,
    input  logic                  res_take,
    input  wct_pkg::entry_t       rdata,
    output wct_pkg::mem_req_t     mem_req,
    output wct_pkg::result_t      res,
    output wct_pkg::ctrl_status_t status
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_PRUNE  = 6'b001000,
        ST_INSERT = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    localparam logic [wct_pkg::IDX_W:0]   CAP_CNT  = (wct_pkg::IDX_W+1)'(wct_pkg::CAPACITY);
    localparam logic [wct_pkg::IDX_W-1:0] LAST_IDX = wct_pkg::IDX_W'(wct_pkg::CAPACITY - 1);

    state_t                    state_reg, state_next;
    logic [wct_pkg::IDX_W:0]   cnt_reg, cnt_next;
    logic                      pend_reg, pend_next;
    logic [wct_pkg::IDX_W-1:0] pidx_reg, pidx_next;
    logic                      free_found_reg, free_found_next;
    logic [wct_pkg::IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [wct_pkg::IDX_W:0]   used_reg, used_next;
    logic                      clr_out_reg, clr_out_next;
    logic [31:0]               addr_reg, addr_next;
    logic [7:0]                wr_reg, wr_next;
    logic [31:0]               now_reg, now_next;
    wct_pkg::result_t          res_reg, res_next;

    logic   issue;
    logic   last;
    logic   hit;
    logic   stale;
    wct_pkg::entry_t new_entry;

    assign issue = (cnt_reg < CAP_CNT);
    assign last  = pend_reg && (pidx_reg == LAST_IDX);
    assign hit   = rdata.valid && (rdata.addr == addr_reg);
    assign stale = rdata.valid && ((now_reg - rdata.frame) > cooldown);
    assign new_entry = '{valid: 1'b1, addr: addr_reg, owner: wr_reg, frame: now_reg};

    assign res    = res_reg;
    assign status = '{idle: (state_reg == ST_IDLE), done: (state_reg == ST_DONE)};

    // Sweep sequencer: clear, lookup, prune and insert.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = 1'b0;
        pidx_next       = pidx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        used_next       = used_reg;
        clr_out_next    = clr_out_reg;
        addr_next       = addr_reg;
        wr_next         = wr_reg;
        now_next        = now_reg;
        res_next        = res_reg;
        mem_req         = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_reg[wct_pkg::IDX_W-1:0];
                mem_req.wdata = '0;
                cnt_next      = cnt_reg + 1'b1;
                used_next     = '0;
                if (cnt_reg[wct_pkg::IDX_W-1:0] == LAST_IDX)
                begin
                    res_next   = '0;
                    state_next = clr_out_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cnt_next        = '0;
                free_found_next = 1'b0;
                if (item_take)
                begin
                    addr_next = address;
                    wr_next   = writer_id;
                    now_next  = frame_number;
                    res_next  = '0;
                    if (cmd == wct_pkg::CMD_CLEAR)
                    begin
                        clr_out_next = 1'b1;
                        state_next   = ST_CLEAR;
                    end
                    else if (writer_id == 8'd0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                mem_req.re    = issue;
                mem_req.raddr = cnt_reg[wct_pkg::IDX_W-1:0];
                pend_next     = issue;
                pidx_next     = cnt_reg[wct_pkg::IDX_W-1:0];
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (pend_reg && hit)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pidx_reg;
                    mem_req.wdata = new_entry;
                    if (rdata.owner != 8'd0 && rdata.owner != wr_reg)
                    begin
                        res_next.conflict     = 1'b1;
                        res_next.contender_id = rdata.owner;
                        res_next.signature    =
                            wct_pkg::pair_signature(wr_reg, rdata.owner, addr_reg);
                    end
                    pend_next  = 1'b0;
                    state_next = ST_DONE;
                end
                else if (pend_reg)
                begin
                    if (!rdata.valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pidx_reg;
                    end
                    if (last)
                    begin
                        pend_next = 1'b0;
                        cnt_next  = '0;
                        state_next = (used_reg < CAP_CNT) ? ST_INSERT : ST_PRUNE;
                    end
                end
            end
            ST_PRUNE:
            begin
                mem_req.re    = issue;
                mem_req.raddr = cnt_reg[wct_pkg::IDX_W-1:0];
                pend_next     = issue;
                pidx_next     = cnt_reg[wct_pkg::IDX_W-1:0];
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (pend_reg && stale)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pidx_reg;
                    mem_req.wdata = '0;
                    used_next     = used_reg - 1'b1;
                    if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pidx_reg;
                    end
                end
                if (last)
                begin
                    pend_next = 1'b0;
                    if (free_found_next)
                    begin
                        state_next = ST_INSERT;
                    end
                    else
                    begin
                        res_next.overflow = 1'b1;
                        state_next        = ST_DONE;
                    end
                end
            end
            ST_INSERT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = free_idx_reg;
                mem_req.wdata = new_entry;
                used_next     = used_reg + 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            free_found_reg <= 1'b0;
            used_reg       <= '0;
            clr_out_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            free_found_reg <= free_found_next;
            used_reg       <= used_next;
            clr_out_reg    <= clr_out_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pidx_reg     <= pidx_next;
        free_idx_reg <= free_idx_next;
        addr_reg     <= addr_next;
        wr_reg       <= wr_next;
        now_reg      <= now_next;
        res_reg      <= res_next;
    end

endmodule

>>> sv/wct_checker.sv
module wct_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        conflict,
    input logic [7:0]  contender_id,
    input logic [33:0] signature,
    input logic        overflow
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(conflict)
            && $stable(contender_id) && $stable(signature) && $stable(overflow))
        else $error("stalled result word changed");

    // A conflict always names a nonzero contender.
    a_contender: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && conflict |-> contender_id != 8'd0)
        else $error("conflict without contender");

    // Without a conflict the contender and signature are zero.
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !conflict |-> contender_id == 8'd0 && signature == 34'd0)
        else $error("nonzero fields without conflict");

    // Overflow and conflict never come together.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> !conflict)
        else $error("overflow together with conflict");

endmodule

bind write_conflict_tracker_unit wct_checker u_wct_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .conflict    (conflict),
    .contender_id(contender_id),
    .signature   (signature),
    .overflow    (overflow)
);
